/* rtl/core/pfc_pkg.sv */
package pfc_pkg;

    localparam int SquareCells = 25;
    localparam int Alphabet    = 26;

    localparam logic [4:0] LETTER_I   = 5'd8;
    localparam logic [4:0] LETTER_J   = 5'd9;
    localparam logic [4:0] LETTER_X   = 5'd23;
    localparam logic [4:0] LETTER_Z   = 5'd25;
    localparam logic [4:0] CELL_COUNT = 5'd25;
    localparam logic [2:0] SIDE_LAST  = 3'd4;

    typedef enum logic [1:0] {
        CMD_KEY      = 2'd0,
        CMD_KEY_DONE = 2'd1,
        CMD_PLAIN    = 2'd2,
        CMD_END      = 2'd3
    } t_cmd;

    // controller -> datapath strobes
    typedef struct packed {
        logic accept;
        logic walk_step;
        logic pos_rd_second;
        logic cap_p1;
        logic calc;
        logic sq_rd_second;
        logic cap_c1;
        logic cap_c2;
        logic out_load;
        logic out_last;
    } t_dp_ctl;

    // datapath -> controller status
    typedef struct packed {
        logic go_fill;
        logic go_pair;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [2:0] pfc_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [4:0] pfc_cell(input logic [2:0] r, input logic [2:0] c);
        return ({2'b00, r} * 5'd5) + {2'b00, c};
    endfunction

    function automatic logic [2:0] pfc_col(input logic [4:0] p);
        logic [4:0] base;
        base = pfc_cell(pfc_row(p), 3'd0);
        return 3'(p - base);
    endfunction

    function automatic logic [2:0] pfc_wrap_inc(input logic [2:0] x);
        return (x == SIDE_LAST) ? 3'd0 : x + 3'd1;
    endfunction

endpackage

/* rtl/core/pfc_datapath.sv */
module pfc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_cmd,
    input  logic [4:0]        i_letter,
    input  logic              i_stall,
    input  pfc_pkg::t_dp_ctl  i_ctl,
    output pfc_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic [4:0]        o_cipher_letter,
    output logic              o_last_of_run
);
    import pfc_pkg::*;

    t_cmd       cmd;
    logic [4:0] ltr_m;
    logic       ltr_ok;
    logic       key_place;
    logic       walk_place;
    logic [4:0] place_ltr;
    logic       do_place;
    logic [4:0] pos_addr;
    logic [4:0] sq_addr;

    logic [4:0] r_square [SquareCells];
    logic [4:0] r_pos [Alphabet];
    logic [4:0] r_sq_q;
    logic [4:0] r_pos_q;

    logic [25:0] r_used;
    logic [4:0]  r_fill;
    logic [4:0]  r_walk;
    logic [4:0]  r_pend_ltr;
    logic        r_pend_valid;
    logic [4:0]  r_first;
    logic [4:0]  r_second;
    logic [4:0]  r_p1;
    logic [4:0]  r_idx1;
    logic [4:0]  r_idx2;
    logic [4:0]  r_c1;
    logic [4:0]  r_c2;
    logic        r_out_valid;
    logic [4:0]  r_out_ltr;
    logic        r_out_last;

    logic [2:0] row1, col1, row2, col2;
    logic [4:0] n_idx1, n_idx2;

    always_comb begin
        cmd        = t_cmd'(i_cmd);
        ltr_m      = (i_letter == LETTER_J) ? LETTER_I : i_letter;
        ltr_ok     = (i_letter <= LETTER_Z);
        key_place  = i_ctl.accept && (cmd == CMD_KEY) && ltr_ok;
        walk_place = i_ctl.walk_step && (r_walk != LETTER_J);
        place_ltr  = i_ctl.walk_step ? r_walk : ltr_m;
        do_place   = (key_place || walk_place) && (r_fill != CELL_COUNT)
                     && !r_used[place_ltr];
        pos_addr   = i_ctl.pos_rd_second ? r_second : r_first;
        sq_addr    = i_ctl.sq_rd_second ? r_idx2 : r_idx1;
    end

    always_comb begin
        o_stat.go_fill   = (cmd == CMD_KEY_DONE);
        o_stat.go_pair   = r_pend_valid
                           && (((cmd == CMD_PLAIN) && ltr_ok) || (cmd == CMD_END));
        o_stat.walk_last = (r_walk == LETTER_Z);
        o_stat.out_free  = !r_out_valid || !i_stall;
    end

    // digraph rules on the two cell positions
    always_comb begin
        row1 = pfc_row(r_p1);
        col1 = pfc_col(r_p1);
        row2 = pfc_row(r_pos_q);
        col2 = pfc_col(r_pos_q);
        if (row1 == row2) begin
            n_idx1 = pfc_cell(row1, pfc_wrap_inc(col1));
            n_idx2 = pfc_cell(row2, pfc_wrap_inc(col2));
        end else if (col1 == col2) begin
            n_idx1 = pfc_cell(pfc_wrap_inc(row1), col1);
            n_idx2 = pfc_cell(pfc_wrap_inc(row2), col2);
        end else begin
            n_idx1 = pfc_cell(row1, col2);
            n_idx2 = pfc_cell(row2, col1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_place) begin
            r_square[r_fill]  <= place_ltr;
            r_pos[place_ltr]  <= r_fill;
        end
        r_pos_q <= r_pos[pos_addr];
        r_sq_q  <= r_square[sq_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_fill       <= '0;
            r_pend_ltr   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (do_place) begin
                r_used[place_ltr] <= 1'b1;
                r_fill            <= r_fill + 5'd1;
            end
            if (i_ctl.accept) begin
                if (cmd == CMD_PLAIN && ltr_ok) begin
                    if (!r_pend_valid) begin
                        r_pend_ltr   <= ltr_m;
                        r_pend_valid <= 1'b1;
                    end else if (r_pend_ltr != ltr_m) begin
                        r_pend_valid <= 1'b0;
                    end
                end else if (cmd == CMD_END) begin
                    r_pend_valid <= 1'b0;
                end
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && cmd == CMD_KEY_DONE) begin
            r_walk <= '0;
        end else if (i_ctl.walk_step) begin
            r_walk <= r_walk + 5'd1;
        end
        if (i_ctl.accept && o_stat.go_pair) begin
            r_first <= r_pend_ltr;
            // a doubled letter, or message end, pairs with X
            r_second <= (cmd == CMD_PLAIN && r_pend_ltr != ltr_m) ? ltr_m : LETTER_X;
        end
        if (i_ctl.cap_p1) begin
            r_p1 <= r_pos_q;
        end
        if (i_ctl.calc) begin
            r_idx1 <= n_idx1;
            r_idx2 <= n_idx2;
        end
        if (i_ctl.cap_c1) begin
            r_c1 <= r_sq_q;
        end
        if (i_ctl.cap_c2) begin
            r_c2 <= r_sq_q;
        end
        if (i_ctl.out_load) begin
            r_out_ltr  <= i_ctl.out_last ? r_c2 : r_c1;
            r_out_last <= i_ctl.out_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cipher_letter = r_out_ltr;
    assign o_last_of_run   = r_out_last;

endmodule

/* rtl/core/pfc_ctrl.sv */
module pfc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pfc_pkg::t_dp_stat i_stat,
    output pfc_pkg::t_dp_ctl  o_ctl,
    output logic              o_busy
);
    import pfc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD1,
        ST_RD2,
        ST_CALC,
        ST_CL1,
        ST_CL2,
        ST_CL3,
        ST_EM1,
        ST_EM2
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                o_ctl.accept = i_valid;
                if (i_valid) begin
                    if (i_stat.go_fill) begin
                        n_state = ST_FILL;
                    end else if (i_stat.go_pair) begin
                        n_state = ST_RD1;
                    end
                end
            end
            ST_FILL: begin
                o_ctl.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD1: begin
                n_state = ST_RD2;
            end
            ST_RD2: begin
                o_ctl.pos_rd_second = 1'b1;
                o_ctl.cap_p1        = 1'b1;
                n_state             = ST_CALC;
            end
            ST_CALC: begin
                o_ctl.calc = 1'b1;
                n_state    = ST_CL1;
            end
            ST_CL1: begin
                n_state = ST_CL2;
            end
            ST_CL2: begin
                o_ctl.sq_rd_second = 1'b1;
                o_ctl.cap_c1       = 1'b1;
                n_state            = ST_CL3;
            end
            ST_CL3: begin
                o_ctl.cap_c2 = 1'b1;
                n_state      = ST_EM1;
            end
            ST_EM1: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_EM2;
                end
            end
            ST_EM2: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

/* rtl/core/playfair_digraph_cipher.sv */
// Playfair encipher block.
// Input words (i_cmd, i_letter) arrive on i_valid/o_stall: key letter, key done,
// plaintext letter, message end. Output words (o_cipher_letter, o_last_of_run)
// leave on o_valid/i_stall; each digraph gives two words, the second with
// o_last_of_run set.
// Key letters, and plaintext letters that only open a digraph, are taken
// without raising o_stall. Key done walks the alphabet through the placement
// logic one letter a cycle. A word that closes a digraph runs through two
// position reads, a rule stage and two square reads (single-port arrays);
// the two cipher letters are then loaded in turn, and the next input word
// is taken the cycle after the second is loaded.
// A one-word output register holds a stalled result; the sequencer waits for
// it to free up before loading the next letter, then takes new input while
// the last letter still waits.
// Reset clears the used-letter mask, fill count, open digraph and output
// valid; the square must be rebuilt with key letters and key done.
module playfair_digraph_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [4:0] i_letter,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [4:0] o_cipher_letter,
    output logic       o_last_of_run
);
    import pfc_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;
    logic     busy;

    pfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    pfc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_letter        (i_letter),
        .i_stall         (i_stall),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_cipher_letter (o_cipher_letter),
        .o_last_of_run   (o_last_of_run)
    );

    assign o_stall = busy;

`ifndef SYNTHESIS
    // never overwrite a word the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> (!o_valid || !i_stall))
        else $error("output word overwritten while stalled");

    // second letter of a digraph frees the input side
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.out_load && ctl.out_last) |=> !o_stall)
        else $error("input not freed after digraph");

    // rule stage follows the first position capture
    a_calc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.calc |-> $past(ctl.cap_p1))
        else $error("rule stage out of order");

    // an accepted word closing a digraph starts the sequence
    a_pair_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.accept && stat.go_pair && !stat.go_fill) |=> o_stall)
        else $error("digraph not started");
`endif

endmodule
